[hw/rtl/timing_protection_counter_table_macros.svh]
// Assertion macros for the timing-protection counter table.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef TIMING_PROTECTION_COUNTER_TABLE_MACROS_SVH
`define TIMING_PROTECTION_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tpct_pkg.sv]
// Shared types and constants for the timing-protection counter table.
// Used by tpct_ctrl, tpct_datapath and the top level; no dependencies.
package tpct_pkg;

  localparam logic [31:0] BOUND_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_START    = 2'd1,
    ACT_STOP_RST = 2'd2,
    ACT_STOP     = 2'd3
  } action_t;

  localparam logic [2:0] KIND_IDLE  = 3'd0;
  localparam logic [2:0] KIND_EXEC  = 3'd1;
  localparam logic [2:0] KIND_ILOCK = 3'd2;
  localparam logic [2:0] KIND_RLOCK = 3'd3;
  localparam logic [2:0] KIND_FRAME = 3'd4;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_EXEC    = 3'd1;
  localparam logic [2:0] EV_LOCK    = 3'd2;
  localparam logic [2:0] EV_ARRIVAL = 3'd3;
  localparam logic [2:0] EV_DELAYED = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_EXEC   = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  // One stored counter entry.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] bound;
    logic [31:0] count;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // latch the accepted input word
    logic rd;      // read the addressed entry
    logic exec;    // apply the update to the entry just read
    logic finish;  // deliver the closing result word
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic walk_done;
    logic stall;     // a held event must leave but the output register is full
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/tpct_ctrl.sv]
// Controller state machine of the timing-protection counter table.
// Depends on tpct_pkg; drives tpct_datapath through cmd_t and reads stat_t.
module tpct_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tpct_pkg::stat_t stat,
  output tpct_pkg::cmd_t  cmd
);
  import tpct_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.stall) begin
          if (stat.is_tick && !stat.walk_done) state_next = ST_READ;
          else state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = !stat.stall;
      end
      ST_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/tpct_datapath.sv]
// Datapath of the timing-protection counter table: entry memory, active bits,
// held event and output register. Depends on tpct_pkg and the assertion macros.
`include "timing_protection_counter_table_macros.svh"

module tpct_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [47:0]     in_data,
  input  tpct_pkg::cmd_t  cmd,
  output tpct_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_res,
  output logic [3:0]      out_entry,
  output logic            out_last
);
  import tpct_pkg::*;

  // Only indexes 0 to 15 can be addressed, so nothing above them is stored.
  localparam int WALK = (ENTRIES < 16) ? ENTRIES : 16;
  localparam int AW   = (WALK > 1) ? $clog2(WALK) : 1;

  // Latched input word.
  action_t     in_action;
  logic [3:0]  in_entry;
  logic [2:0]  in_kind;
  logic [31:0] in_budget;
  logic        in_trusted;
  logic        in_delay;

  logic [AW-1:0]   walk;
  logic [WALK-1:0] active;
  logic [WALK-1:0] written;
  entry_t          mem [WALK];
  entry_t          rd_word;
  logic            rd_written;

  logic        pend_valid;
  logic [2:0]  pend_res;
  logic [3:0]  pend_entry;

  logic [AW-1:0] addr;
  logic          is_tick;
  logic          in_range;
  logic          walk_done;
  logic          out_free;
  entry_t        cur;
  entry_t        wword;
  logic          we;
  logic          act_we;
  logic          act_val;
  logic          ev_valid;
  logic [2:0]    ev_res;
  logic [31:0]   cnt_inc;
  logic          hit;
  logic          push_mid;

  assign is_tick   = (in_action == ACT_TICK);
  assign in_range  = ({1'b0, in_entry} < 5'(WALK));
  assign addr      = is_tick ? walk : in_entry[AW-1:0];
  assign walk_done = (walk == AW'(WALK - 1));
  assign out_free  = !out_valid || out_ready;

  // An entry never written reads as its reset value.
  always_comb begin
    if (rd_written) begin
      cur = rd_word;
    end else begin
      cur.kind  = KIND_IDLE;
      cur.bound = BOUND_NONE;
      cur.count = 32'd0;
    end
  end

  assign cnt_inc = (cur.bound != BOUND_NONE) ? cur.count + 32'd1 : cur.count;
  assign hit     = (cnt_inc >= cur.bound);

  always_comb begin
    wword    = cur;
    we       = 1'b0;
    act_we   = 1'b0;
    act_val  = 1'b0;
    ev_valid = 1'b0;
    ev_res   = EV_NONE;
    if (is_tick) begin
      if (active[addr]) begin
        we          = 1'b1;
        wword.count = cnt_inc;
        if (hit) begin
          case (cur.kind) inside
            KIND_IDLE: wword.count = 32'd0;
            KIND_EXEC: begin
              ev_valid = 1'b1;
              ev_res   = (in_trusted && in_delay) ? EV_DELAYED : EV_EXEC;
            end
            KIND_ILOCK, KIND_RLOCK: begin
              ev_valid = 1'b1;
              ev_res   = EV_LOCK;
            end
            KIND_FRAME: begin
              act_we  = 1'b1;
              act_val = 1'b0;
            end
            default: ;
          endcase
        end
      end
    end else if (in_range) begin
      case (in_action)
        ACT_START: begin
          we          = 1'b1;
          act_we      = 1'b1;
          act_val     = 1'b1;
          wword.kind  = in_kind;
          wword.bound = in_budget;
          if (in_kind == KIND_FRAME) begin
            ev_valid    = (cur.count < in_budget);
            ev_res      = EV_ARRIVAL;
            wword.count = 32'd1;
          end
        end
        ACT_STOP_RST: begin
          we     = 1'b1;
          act_we = 1'b1;
          if (cur.kind == KIND_FRAME) begin
            wword.count = cur.bound;
          end else begin
            wword.count = 32'd0;
            wword.bound = BOUND_NONE;
          end
        end
        ACT_STOP: act_we = 1'b1;
        default: ;
      endcase
    end
  end

  assign push_mid = cmd.exec && ev_valid && pend_valid;

  assign stat.is_tick   = is_tick;
  assign stat.walk_done = walk_done;
  assign stat.stall     = ev_valid && pend_valid && !out_free;
  assign stat.out_free  = out_free;

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[addr] <= wword;
    if (cmd.rd) rd_word <= mem[addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_action  <= action_t'(in_data[1:0]);
      in_entry   <= in_data[5:2];
      in_kind    <= in_data[8:6];
      in_budget  <= in_data[40:9];
      in_trusted <= in_data[41];
      in_delay   <= in_data[42];
    end
    if (cmd.exec && ev_valid) begin
      pend_res   <= ev_res;
      pend_entry <= 4'(addr);
    end
    if (push_mid) begin
      out_res   <= pend_res;
      out_entry <= pend_entry;
      out_last  <= 1'b0;
    end else if (cmd.finish) begin
      out_res   <= pend_valid ? pend_res : EV_NONE;
      out_entry <= pend_valid ? pend_entry : 4'd0;
      out_last  <= 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk       <= '0;
      active     <= '0;
      written    <= '0;
      rd_written <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) walk <= '0;
      else if (cmd.exec && is_tick && !walk_done) walk <= walk + AW'(1);
      if (cmd.rd) rd_written <= written[addr];
      if (cmd.exec && we) written[addr] <= 1'b1;
      if (cmd.exec && act_we) active[addr] <= act_val;
      if (cmd.finish) pend_valid <= 1'b0;
      else if (cmd.exec && ev_valid) pend_valid <= 1'b1;
      if (push_mid || cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `TPCT_ASSERT_IMP(a_load_no_pend, clk, rst, cmd.load, !pend_valid, "held event left at input accept")
  `TPCT_ASSERT_IMP(a_mid_room, clk, rst, push_mid, out_free, "event pushed into a full output register")
  `TPCT_ASSERT_IMP(a_fin_room, clk, rst, cmd.finish, out_free, "final word pushed into a full output register")
  `TPCT_ASSERT_NXT(a_load_walk, clk, rst, cmd.load, walk == '0, "walk index not cleared at input accept")

endmodule

[hw/rtl/timing_protection_counter_table.sv]
// Top level of the timing-protection counter table.
// Depends on tpct_pkg, tpct_ctrl and tpct_datapath.
//
//   Channel | Direction | Handshake          | Payload
//   s_*     | in        | s_tvalid/s_tready  | s_tdata: command word
//   m_*     | out       | m_tvalid/m_tready  | m_tdata + m_tlast: event word
//
// A tick walks N = min(ENTRIES, 16) stored entries: each entry is read from the
// entry memory in ST_READ and updated in ST_EXEC; start and stop commands pass
// through both states once. Reset clears all entries at once through per-entry
// valid bits. A full output register stalls the walk only when a second event
// is ready; a new command is taken while the last event word still waits.
module timing_protection_counter_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], entry[5:2], kind[8:6], budget[40:9], in_trusted_call[41],
  // delay_allowed[42], zero fill[47:43]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // event_res[2:0], event_entry[6:3], zero fill[7]
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);
  import tpct_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] out_res;
  logic [3:0] out_entry;

  tpct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .out_entry (out_entry),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_entry, out_res};

endmodule

[tb/sv/tb_timing_protection_counter_table.sv]
// Self-checking testbench for the timing-protection counter table.
// Depends on tpct_pkg and timing_protection_counter_table; drives command words
// and checks every event word against a counter-table predictor or a fixed event.
`timescale 1ns / 100ps

module tb_timing_protection_counter_table;
  import tpct_pkg::*;

  localparam int NUM_ENTRIES    = 16;
  localparam int RANDOM_CMDS    = 445;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  // Kinds that carry no meaning; they are stored but never act at the bound.
  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  // Fields of one command word, action in the lowest bits.
  typedef struct packed {
    logic        delay_ok;
    logic        trusted;
    logic [31:0] budget;
    logic [2:0]  kind;
    logic [3:0]  entry;
    action_t     act;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0] res;
    logic [3:0] entry;
    logic       last;
  } event_word_t;

  // Directed command with an optional hand-written single event.
  typedef struct {
    cmd_word_t  cmd;
    bit         fixed;
    logic [2:0] res;
    logic [3:0] entry;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  timing_protection_counter_table #(.ENTRIES(NUM_ENTRIES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted counter table.
  logic        ctr_active [NUM_ENTRIES];
  logic [2:0]  ctr_kind   [NUM_ENTRIES];
  logic [31:0] ctr_bound  [NUM_ENTRIES];
  logic [31:0] ctr_count  [NUM_ENTRIES];

  event_word_t step_events[$];
  event_word_t pending_events[$];
  plan_row_t   plan[$];

  int failures = 0;
  int n_cmds = 0;
  int n_ticks = 0;
  int n_events = 0;
  int idle_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  function automatic void add_event(logic [2:0] res, logic [3:0] entry);
    event_word_t w;
    w.res   = res;
    w.entry = entry;
    w.last  = 1'b0;
    step_events.push_back(w);
  endfunction

  // Applies one command to the predicted table and leaves its events in step_events.
  function automatic void update_counters(cmd_word_t c);
    step_events.delete();
    if (c.act == ACT_TICK) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (ctr_active[i]) begin
          if (ctr_bound[i] != BOUND_NONE) ctr_count[i] = ctr_count[i] + 32'd1;
          if (ctr_count[i] >= ctr_bound[i]) begin
            case (ctr_kind[i])
              KIND_IDLE: ctr_count[i] = '0;
              KIND_EXEC: add_event((c.trusted && c.delay_ok) ? EV_DELAYED : EV_EXEC, i[3:0]);
              KIND_ILOCK, KIND_RLOCK: add_event(EV_LOCK, i[3:0]);
              KIND_FRAME: ctr_active[i] = 1'b0;
              default: ;
            endcase
          end
        end
      end
    end else if (c.act == ACT_START) begin
      if (c.kind == KIND_FRAME) begin
        if (ctr_count[c.entry] < c.budget) add_event(EV_ARRIVAL, c.entry);
        ctr_count[c.entry] = 32'd1;
      end
      ctr_active[c.entry] = 1'b1;
      ctr_kind[c.entry]   = c.kind;
      ctr_bound[c.entry]  = c.budget;
    end else if (c.act == ACT_STOP_RST) begin
      ctr_active[c.entry] = 1'b0;
      // A frame keeps its bound and is left expired; others are cleared.
      if (ctr_kind[c.entry] == KIND_FRAME) begin
        ctr_count[c.entry] = ctr_bound[c.entry];
      end else begin
        ctr_count[c.entry] = '0;
        ctr_bound[c.entry] = BOUND_NONE;
      end
    end else begin
      ctr_active[c.entry] = 1'b0;
    end
    if (step_events.size() == 0) add_event(EV_NONE, 4'd0);
    step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  task automatic plan_row(action_t act, int entry, logic [2:0] kind, logic [31:0] budget,
                          bit trusted, bit delay_ok, bit fixed,
                          logic [2:0] res = EV_NONE, logic [3:0] ev_entry = 4'd0);
    plan_row_t r;
    r.cmd.act      = act;
    r.cmd.entry    = entry[3:0];
    r.cmd.kind     = kind;
    r.cmd.budget   = budget;
    r.cmd.trusted  = trusted;
    r.cmd.delay_ok = delay_ok;
    r.fixed        = fixed;
    r.res          = res;
    r.entry        = ev_entry;
    plan.push_back(r);
  endtask

  // Offers one command word, waits for it to be taken and queues its events.
  task automatic send_command(plan_row_t r);
    int gap;
    event_word_t w;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, r.cmd};
    do @(posedge clk); while (s_tready !== 1'b1);
    update_counters(r.cmd);
    if (r.fixed) begin
      w.res   = r.res;
      w.entry = r.entry;
      w.last  = 1'b1;
      pending_events.push_back(w);
    end else begin
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    end
    n_cmds++;
    if (r.cmd.act == ACT_TICK) n_ticks++;
  endtask

  function automatic logic [31:0] pick_budget();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 6);
    if (r < 70) return $urandom;
    if (r < 80) return BOUND_NONE;
    if (r < 90) return BOUND_NONE - $urandom_range(1, 4);
    return $urandom_range(7, 40);
  endfunction

  initial begin : stimulus
    plan_row_t r;
    int pick;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ctr_active[i] = 1'b0;
      ctr_kind[i]   = KIND_IDLE;
      ctr_bound[i]  = BOUND_NONE;
      ctr_count[i]  = '0;
    end

    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_START,     0, KIND_EXEC,   32'd2,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        0, 0, 0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        0, 1, 0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        1, 1, 0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        1, 0, 0);
    plan_row(ACT_START,    15, KIND_FRAME,  BOUND_NONE,   1, 1, 1, EV_ARRIVAL, 4'd15);
    plan_row(ACT_START,     1, KIND_ILOCK,  32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_START,     2, KIND_RLOCK,  32'd1,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_START,     3, KIND_IDLE,   32'd1,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_START,     4, KIND_SPARE7, 32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_START,     5, KIND_FRAME,  32'd1,        0, 0, 1, EV_ARRIVAL, 4'd5);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        1, 1, 0);
    plan_row(ACT_START,     5, KIND_FRAME,  32'd0,        0, 0, 0);
    plan_row(ACT_STOP_RST,  5, KIND_IDLE,   32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_STOP_RST,  0, KIND_IDLE,   32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_STOP,      1, KIND_IDLE,   32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_STOP,      9, KIND_IDLE,   32'd0,        0, 0, 1, EV_NONE, 4'd0);
    // Park a frame at the top of the count range so a spare kind can wrap it.
    plan_row(ACT_START,     7, KIND_FRAME,  32'hFFFF_FFFE, 0, 0, 1, EV_ARRIVAL, 4'd7);
    plan_row(ACT_STOP_RST,  7, KIND_IDLE,   32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_START,     7, KIND_SPARE5, 32'd0,        0, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        0, 0, 0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        1, 1, 0);
    plan_row(ACT_START,     2, KIND_RLOCK,  32'd5,        1, 0, 1, EV_NONE, 4'd0);
    plan_row(ACT_TICK,      0, KIND_IDLE,   32'd0,        0, 1, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_command(plan[i]);

    r.fixed = 1'b0;
    r.res   = EV_NONE;
    r.entry = 4'd0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.cmd.act = ACT_TICK;
      else if (pick < 72) r.cmd.act = ACT_START;
      else if (pick < 86) r.cmd.act = ACT_STOP_RST;
      else                r.cmd.act = ACT_STOP;
      r.cmd.entry    = 4'($urandom_range(0, NUM_ENTRIES - 1));
      r.cmd.kind     = 3'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 4)
                                                       : $urandom_range(5, 7));
      r.cmd.budget   = pick_budget();
      r.cmd.trusted  = 1'($urandom_range(0, 1));
      r.cmd.delay_ok = 1'($urandom_range(0, 1));
      send_command(r);
    end
    s_tvalid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command words (%0d ticks) and checked %0d event words.",
             n_cmds, n_ticks, n_events);
    $display("Counter kinds, bounds from zero to all ones and count wrap were exercised.");
    if (failures == 0 && pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : event_sink
    int stall;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1 || rst);
    end
  end

  always @(posedge clk) begin
    event_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_events++;
      if (pending_events.size() == 0) begin
        $error("unexpected event word: event_res %0d event_entry %0d last %0b",
               m_tdata[2:0], m_tdata[6:3], m_tlast);
        failures++;
      end else begin
        want = pending_events.pop_front();
        if (m_tdata[2:0] !== want.res) begin
          $error("event_res: expected %0d, got %0d", want.res, m_tdata[2:0]);
          failures++;
        end
        if (m_tdata[6:3] !== want.entry) begin
          $error("event_entry: expected %0d, got %0d", want.entry, m_tdata[6:3]);
          failures++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          failures++;
        end
      end
    end
  end

  // Ends a run that stops moving words in either direction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
